/* hdl/pft_pkg.sv */
package pft_pkg;

  // Sizing of the palette store and the fade sequence.
  localparam int FADE_TICKS      = 30;
  localparam int PALETTE_ENTRIES = 256;

  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W   = $clog2(FADE_TICKS + 1);
  localparam int TAB_AW  = (FADE_TICKS > 1) ? $clog2(FADE_TICKS) : 1;
  localparam int LEVEL_W = 5;
  localparam int COLOR_W = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(16);
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = LEVEL_W'(1);
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CHECK = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_OUT  = 2'd1,
    PH_LOAD = 2'd2,
    PH_IN   = 2'd3
  } phase_t;

  // Exit direction codes.
  localparam logic [1:0] EXIT_UP    = 2'd0;
  localparam logic [1:0] EXIT_DOWN  = 2'd1;
  localparam logic [1:0] EXIT_LEFT  = 2'd2;
  localparam logic [1:0] EXIT_RIGHT = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         palette_index;
    logic [14:0]        write_color;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]         neighbor_mask;
  } in_item_t;

  typedef struct packed {
    logic [14:0] read_color;
    logic [1:0]  phase;
    logic [1:0]  exit_direction;
    logic [4:0]  brightness_out;
  } out_item_t;

  // Sequencer state as it stands after the accepted transaction.
  typedef struct packed {
    logic [1:0]         phase;
    logic [1:0]         exit_dir;
    logic [LEVEL_W-1:0] level;
  } seq_status_t;

  // Fade ramp: count*16/FADE_TICKS for every count below FADE_TICKS.
  typedef logic [LEVEL_W-1:0] fade_tab_t [FADE_TICKS];

  function automatic fade_tab_t build_fade_tab();
    fade_tab_t t;
    for (int i = 0; i < FADE_TICKS; i++) begin
      t[i] = LEVEL_W'((i * 16) / FADE_TICKS);
    end
    return t;
  endfunction

  localparam fade_tab_t FADE_TAB = build_fade_tab();

endpackage

/* hdl/palette_fade_transition_engine_top.sv */
// Palette fade engine: a 256-entry RGB15 palette with a fade-out, load,
// fade-in sequencer driven by position checks and frame ticks. One
// transaction is accepted per clock unless the output stalls, and each
// gives one result through the synchronous palette RAM read and then the
// output register that scales the color by the brightness level. The
// palette reads as black after reset through per-entry written flags, so
// no clearing pass is needed. Configuration writes are always accepted
// and must only be issued while the block is idle.
module palette_fade_transition_engine_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pft_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pft_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [14:0]                       cfg_data
);

  logic                          in_fire;
  logic                          cfg_fire;
  logic                          in_range;
  logic                          wr_en;
  logic                          read_hit;
  logic [pft_pkg::PAL_AW-1:0]    pal_addr;
  logic [pft_pkg::COLOR_W-1:0]   mem_data;
  logic [pft_pkg::LEVEL_W-1:0]   level;
  pft_pkg::seq_status_t          status_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;

  // Palette addressing; indexes past the palette are dropped.
  assign in_range = 32'(in_data.palette_index) < pft_pkg::PALETTE_ENTRIES;
  assign pal_addr = pft_pkg::PAL_AW'(in_data.palette_index);
  assign wr_en    = in_fire && in_range && (in_data.req_type == pft_pkg::REQ_WRITE);
  assign read_hit = in_range && (in_data.req_type == pft_pkg::REQ_READ);

  pft_palette_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (pal_addr),
    .wr_data (in_data.write_color),
    .rd_en   (in_fire),
    .rd_addr (pal_addr),
    .rd_data (mem_data)
  );

  pft_sequencer u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (in_fire),
    .item       (in_data),
    .cfg_fire   (cfg_fire),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status_nxt (status_nxt),
    .level      (level)
  );

  pft_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (in_fire),
    .read_hit    (read_hit && (level == status_nxt.level)),
    .status_nxt  (status_nxt),
    .mem_data    (mem_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .stage_ready (in_ready)
  );

endmodule

/* hdl/pft_palette_mem.sv */
module pft_palette_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [pft_pkg::PAL_AW-1:0]        wr_addr,
  input  logic [pft_pkg::COLOR_W-1:0]       wr_data,
  input  logic                              rd_en,
  input  logic [pft_pkg::PAL_AW-1:0]        rd_addr,
  output logic [pft_pkg::COLOR_W-1:0]       rd_data
);

  logic [pft_pkg::COLOR_W-1:0] mem_r [pft_pkg::PALETTE_ENTRIES];
  logic [pft_pkg::PALETTE_ENTRIES-1:0] vld_r;
  logic [pft_pkg::COLOR_W-1:0] rd_data_r;
  logic                        rd_vld_r;

  // Color storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Per-entry written flags; an entry never written reads as black.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* hdl/pft_sequencer.sv */
module pft_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_fire,
  input  pft_pkg::in_item_t                 item,
  input  logic                              cfg_fire,
  input  logic [pft_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [14:0]                       cfg_data,
  output pft_pkg::seq_status_t              status_nxt,
  output logic [pft_pkg::LEVEL_W-1:0]       level
);

  pft_pkg::phase_t                 phase_r, phase_nxt;
  logic [pft_pkg::CNT_W-1:0]       count_r, count_nxt, count_inc;
  logic [pft_pkg::LEVEL_W-1:0]     level_r, level_nxt;
  logic [1:0]                      dir_r, dir_nxt;
  logic [14:0]                     width_r, height_r;
  logic [pft_pkg::LEVEL_W-1:0]     ramp;
  logic                            x_neg, y_neg, x_beyond, y_beyond;

  // Section bounds registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 15'd240;
      height_r <= 15'd160;
    end else if (cfg_fire) begin
      if (cfg_index == pft_pkg::CFG_SECTION_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == pft_pkg::CFG_SECTION_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pft_pkg::PH_IDLE;
      count_r <= '0;
      level_r <= pft_pkg::LEVEL_FULL;
      dir_r   <= pft_pkg::EXIT_UP;
    end else if (item_fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      level_r <= level_nxt;
      dir_r   <= dir_nxt;
    end
  end

  // Position compares against the section bounds.
  assign x_neg    = item.pos_x[15];
  assign y_neg    = item.pos_y[15];
  assign x_beyond = item.pos_x[15:0] >= {1'b0, width_r};
  assign y_beyond = item.pos_y[15:0] >= {1'b0, height_r};

  assign count_inc = count_r + pft_pkg::CNT_W'(1);
  assign ramp      = pft_pkg::FADE_TAB[count_inc[pft_pkg::TAB_AW-1:0]];

  // Next state for checks and frame ticks.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    level_nxt = level_r;
    dir_nxt   = dir_r;
    unique case (item.req_type)
      pft_pkg::REQ_CHECK: begin
        if (phase_r == pft_pkg::PH_IDLE) begin
          priority if (x_neg) begin
            if (item.neighbor_mask[0]) begin
              dir_nxt   = pft_pkg::EXIT_LEFT;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_OUT;
            end
          end else if (x_beyond) begin
            if (item.neighbor_mask[1]) begin
              dir_nxt   = pft_pkg::EXIT_RIGHT;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_OUT;
            end
          end else if (y_neg) begin
            if (item.neighbor_mask[2]) begin
              dir_nxt   = pft_pkg::EXIT_UP;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_OUT;
            end
          end else if (y_beyond) begin
            if (item.neighbor_mask[3]) begin
              dir_nxt   = pft_pkg::EXIT_DOWN;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_OUT;
            end
          end else begin
            dir_nxt = dir_r;
          end
        end
      end
      pft_pkg::REQ_TICK: begin
        unique case (phase_r)
          pft_pkg::PH_IDLE: begin
            phase_nxt = phase_r;
          end
          pft_pkg::PH_OUT: begin
            if (count_inc == pft_pkg::CNT_W'(pft_pkg::FADE_TICKS)) begin
              level_nxt = pft_pkg::LEVEL_ZERO;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_LOAD;
            end else begin
              level_nxt = pft_pkg::LEVEL_FULL - ramp;
              count_nxt = count_inc;
            end
          end
          pft_pkg::PH_LOAD: begin
            phase_nxt = pft_pkg::PH_IN;
            count_nxt = '0;
          end
          pft_pkg::PH_IN: begin
            if (count_inc == pft_pkg::CNT_W'(pft_pkg::FADE_TICKS)) begin
              level_nxt = pft_pkg::LEVEL_FULL;
              count_nxt = '0;
              phase_nxt = pft_pkg::PH_IDLE;
            end else begin
              // The ramp stays below 16, so the fade-in level never exceeds full.
              level_nxt = pft_pkg::LEVEL_ONE + ramp;
              count_nxt = count_inc;
            end
          end
        endcase
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign status_nxt.phase    = phase_nxt;
  assign status_nxt.exit_dir = dir_nxt;
  assign status_nxt.level    = level_nxt;
  assign level               = level_r;

endmodule

/* hdl/pft_out_stage.sv */
module pft_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_fire,
  input  logic                              read_hit,
  input  pft_pkg::seq_status_t              status_nxt,
  input  logic [pft_pkg::COLOR_W-1:0]       mem_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output pft_pkg::out_item_t                out_data,
  output logic                              stage_ready
);

  logic                    s1_valid_r;
  logic                    s1_hit_r;
  pft_pkg::seq_status_t    s1_status_r;
  logic                    out_valid_r;
  pft_pkg::out_item_t      out_data_r;
  logic                    s1_adv;
  logic [9:0]              prod_r, prod_g, prod_b;
  logic [14:0]             scaled;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign stage_ready = !s1_valid_r || !out_valid_r || out_ready;

  // Stage one waits for the palette read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= item_fire || (s1_valid_r && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_hit_r    <= read_hit;
      s1_status_r <= status_nxt;
    end
  end

  // Scale each 5-bit component by the brightness level, divided by 16.
  assign prod_r = 10'(mem_data[4:0])   * 10'(s1_status_r.level);
  assign prod_g = 10'(mem_data[9:5])   * 10'(s1_status_r.level);
  assign prod_b = 10'(mem_data[14:10]) * 10'(s1_status_r.level);
  assign scaled = {prod_b[8:4], prod_g[8:4], prod_r[8:4]};

  // Output register holds the result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_adv || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.read_color     <= s1_hit_r ? scaled : '0;
      out_data_r.phase          <= s1_status_r.phase;
      out_data_r.exit_direction <= s1_status_r.exit_dir;
      out_data_r.brightness_out <= s1_status_r.level;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
